[design/lage_pkg.sv]
// ----------------------------------------------------------------------------
// lage_pkg
// Shared types and constants of the life automaton grid engine: request
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lage_pkg;

  // request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_READ  = 2'd2
  } lage_req_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_WAIT,
    ST_SWEEP
  } lage_state_e;

  // B3/S23 neighbour counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic cnt_clr;    // reset sweep counter and row window
    logic clear_wr;   // post-reset clearing write
    logic user_wr;    // row write transaction
    logic user_rd;    // row read transaction
    logic sweep;      // generation sweep cycle
    logic out_load;   // load result register
  } lage_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic sweep_last;
  } lage_status_t;

endpackage

`default_nettype wire

[design/lage_ctrl.sv]
// ----------------------------------------------------------------------------
// lage_ctrl
// Controller state machine: clearing pass, request dispatch, read result
// hand-off and generation sweep sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module lage_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic [1:0]            req_type_i,
  input  wire logic                  out_ready_i,
  input  wire lage_pkg::lage_status_t status_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  output lage_pkg::lage_cmd_t        cmd_o
);

  lage_pkg::lage_state_e state_q, state_d;
  lage_pkg::lage_req_e   req;
  logic                  out_valid_q, out_valid_d;
  logic                  in_acc;
  logic                  out_free;

  assign req      = lage_pkg::lage_req_e'(req_type_i);
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lage_pkg::ST_CLEAR: begin
        if (status_i.clear_last) state_d = lage_pkg::ST_IDLE;
      end
      lage_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (req)
            lage_pkg::REQ_STEP: state_d = lage_pkg::ST_SWEEP;
            lage_pkg::REQ_READ: state_d = lage_pkg::ST_READ_WAIT;
            default:            state_d = lage_pkg::ST_IDLE;
          endcase
        end
      end
      lage_pkg::ST_READ_WAIT: begin
        if (out_free) state_d = lage_pkg::ST_IDLE;
      end
      lage_pkg::ST_SWEEP: begin
        if (status_i.sweep_last) state_d = lage_pkg::ST_IDLE;
      end
      default: state_d = lage_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      lage_pkg::ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        cmd_o.cnt_clr  = status_i.clear_last;
      end
      lage_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          case (req)
            lage_pkg::REQ_WRITE: cmd_o.user_wr = 1'b1;
            lage_pkg::REQ_STEP:  cmd_o.cnt_clr = 1'b1;
            lage_pkg::REQ_READ:  cmd_o.user_rd = 1'b1;
            default:             cmd_o         = '0;
          endcase
        end
      end
      lage_pkg::ST_READ_WAIT: begin
        cmd_o.out_load = out_free;
      end
      lage_pkg::ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lage_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[design/lage_datapath.sv]
// ----------------------------------------------------------------------------
// lage_datapath
// Grid row memory, three-row sliding window with per-column B3/S23 lanes,
// sweep counter and read result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lage_datapath #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lage_pkg::lage_cmd_t    cmd_i,
  input  wire logic [5:0]             row_index_i,
  input  wire logic [63:0]            row_cells_i,
  output lage_pkg::lage_status_t      status_o,
  output logic [5:0]                  read_row_index_o,
  output logic [63:0]                 read_row_cells_o
);

  localparam int AW   = $clog2(ROWS);
  localparam int CNTW = $clog2(ROWS + 2);

  logic [COLS-1:0] mem [ROWS];

  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [CNTW-1:0] sweep_row;
  logic [COLS-1:0] above_q, mid_q, rdata_q, below;
  logic [COLS-1:0] next_row;
  logic [5:0]      rd_idx_q, out_idx_q;
  logic            rd_oob_q;
  logic [63:0]     out_cells_q;
  logic            row_ok;
  logic            sweep_wr, sweep_rd, shift;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [COLS-1:0] wdata;

  assign row_ok    = 32'(row_index_i) < ROWS;
  assign sweep_wr  = cmd_i.sweep && (cnt_q >= CNTW'(2));
  assign sweep_rd  = cmd_i.sweep && (cnt_q < CNTW'(ROWS));
  assign shift     = cmd_i.sweep && (cnt_q != '0);
  assign sweep_row = cnt_q - CNTW'(2);

  // row below the grid reads as dead
  assign below = (cnt_q == CNTW'(ROWS + 1)) ? '0 : rdata_q;

  assign status_o.clear_last = (cnt_q == CNTW'(ROWS - 1));
  assign status_o.sweep_last = (cnt_q == CNTW'(ROWS + 1));

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd_i.clear_wr) begin
      we    = 1'b1;
      waddr = cnt_q[AW-1:0];
    end else if (sweep_wr) begin
      we    = 1'b1;
      waddr = sweep_row[AW-1:0];
      wdata = next_row;
    end else if (cmd_i.user_wr && row_ok) begin
      we    = 1'b1;
      waddr = AW'(row_index_i);
      wdata = row_cells_i[COLS-1:0];
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (sweep_rd) begin
      re    = 1'b1;
      raddr = cnt_q[AW-1:0];
    end else if (cmd_i.user_rd && row_ok) begin
      re    = 1'b1;
      raddr = AW'(row_index_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // per-column rule lanes over zero-padded window rows
  logic [COLS+1:0] up_p, md_p, dn_p;
  assign up_p = {1'b0, above_q, 1'b0};
  assign md_p = {1'b0, mid_q, 1'b0};
  assign dn_p = {1'b0, below, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    logic [3:0] nbr_cnt;
    assign nbr_cnt = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
                   + 4'(md_p[c]) + 4'(md_p[c+2])
                   + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
    assign next_row[c] = (nbr_cnt == lage_pkg::BIRTH_COUNT)
                      || (md_p[c+1] && (nbr_cnt == lage_pkg::SURVIVE_COUNT));
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) cnt_d = '0;
    else if (cmd_i.clear_wr || cmd_i.sweep) cnt_d = cnt_q + CNTW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  // window, read tag and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_clr) begin
      above_q <= '0;
      mid_q   <= '0;
    end else if (shift) begin
      above_q <= mid_q;
      mid_q   <= below;
    end
    if (cmd_i.user_rd) begin
      rd_idx_q <= row_index_i;
      rd_oob_q <= !row_ok;
    end
    if (cmd_i.out_load) begin
      out_idx_q   <= rd_idx_q;
      out_cells_q <= rd_oob_q ? '0 : 64'(rdata_q);
    end
  end

  assign read_row_index_o = out_idx_q;
  assign read_row_cells_o = out_cells_q;

endmodule

`default_nettype wire

[design/life_automaton_grid_engine_unit.sv]
// ----------------------------------------------------------------------------
// life_automaton_grid_engine_unit
// B3/S23 cellular automaton over a ROWS by COLS grid held in a row memory.
// ----------------------------------------------------------------------------
// write: accepted while idle, ready again the next cycle
// read: result passes through the read-wait state into the result register; one read in flight at a time
// advance: a sweep through a three-row window on the single read
//   and write port of the row memory, ready again after that
// reset: a clearing pass writes every row dead, with ready low
`default_nettype none

module life_automaton_grid_engine_unit #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [5:0]  row_index_i,
  input  wire logic [63:0] row_cells_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       read_row_index_o,
  output logic [63:0]      read_row_cells_o
);

  lage_pkg::lage_cmd_t    cmd;
  lage_pkg::lage_status_t status;

  lage_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  lage_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .row_index_i      (row_index_i),
    .row_cells_i      (row_cells_i),
    .status_o         (status),
    .read_row_index_o (read_row_index_o),
    .read_row_cells_o (read_row_cells_o)
  );

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register loaded while holding an untaken result");

  // only one source writes the row memory in a cycle
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear_wr, cmd.sweep, cmd.user_wr}))
    else $error("conflicting row memory writes");

  // a read transaction blocks input until its result is loaded
  a_read_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == lage_pkg::REQ_READ)) |=> !in_ready_o)
    else $error("input accepted while a read is outstanding");

  // a step transaction starts a sweep with a cleared counter
  a_step_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == lage_pkg::REQ_STEP))
      |=> (cmd.sweep && !in_ready_o))
    else $error("step transaction did not start a sweep");

endmodule

`default_nettype wire

[verif/tb_life_automaton_grid_engine_unit.sv]
// ----------------------------------------------------------------------------
// tb_life_automaton_grid_engine_unit
// Self-checking bench for the B3/S23 grid engine. Row writes, generation
// steps and row reads go in over a valid/ready channel with random gaps.
// A local copy of the grid, or a value pinned in the table, predicts every
// read, and read results are checked in order under random back-pressure.
// ----------------------------------------------------------------------------
module tb_life_automaton_grid_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 64;
  localparam int COLS = 64;
  localparam logic [63:0] COL_MASK = (COLS >= 64) ? '1 : ((64'd1 << COLS) - 64'd1);
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int DIRECTED_LEN = 25;
  localparam int RANDOM_REQS = 1900;

  typedef struct packed {
    logic [1:0]  req;
    logic [5:0]  row;
    logic [63:0] cells;
    logic        pinned;  // expected read value given in the table
    logic [63:0] want;
  } grid_req_t;

  typedef struct packed {
    logic [5:0]  row;
    logic [63:0] cells;
  } row_read_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  req_type_i = '0;
  logic [5:0]  row_index_i = '0;
  logic [63:0] row_cells_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  read_row_index_o;
  logic [63:0] read_row_cells_o;

  logic [63:0] life_grid [ROWS];
  row_read_t   pending_reads [$];
  int          mismatch_count = 0;
  int          served_reqs = 0;
  int          tx_calm = 0;
  int          rx_calm = 0;
  int          rx_stall = 0;

  grid_req_t directed_tbl [DIRECTED_LEN] = '{
    '{lage_pkg::REQ_READ,  6'd0,  64'd0,                  1'b1, 64'd0},
    '{lage_pkg::REQ_READ,  6'd63, 64'd0,                  1'b1, 64'd0},
    '{lage_pkg::REQ_WRITE, 6'd0,  '1,                     1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd0,  64'd0,                  1'b1, '1},
    '{lage_pkg::REQ_WRITE, 6'd63, 64'h8000_0000_0000_0001, 1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd63, 64'd0,                  1'b1, 64'h8000_0000_0000_0001},
    '{REQ_UNUSED,          6'd0,  64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd0,  64'd0,                  1'b1, '1},
    '{lage_pkg::REQ_STEP,  6'd0,  64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd0,  64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd1,  64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd62, 64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd63, 64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_WRITE, 6'd0,  64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_WRITE, 6'd1,  64'd0,                  1'b0, 64'd0},
    // blinker on the right edge, block on the left edge
    '{lage_pkg::REQ_WRITE, 6'd20, 64'hE000_0000_0000_0000, 1'b0, 64'd0},
    '{lage_pkg::REQ_WRITE, 6'd40, 64'h3,                  1'b0, 64'd0},
    '{lage_pkg::REQ_WRITE, 6'd41, 64'h3,                  1'b0, 64'd0},
    '{lage_pkg::REQ_STEP,  6'd0,  64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd19, 64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd20, 64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd21, 64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd41, 64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_STEP,  6'd0,  64'd0,                  1'b0, 64'd0},
    '{lage_pkg::REQ_READ,  6'd20, 64'd0,                  1'b0, 64'd0}
  };

  life_automaton_grid_engine_unit #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .row_index_i      (row_index_i),
    .row_cells_i      (row_cells_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_row_index_o (read_row_index_o),
    .read_row_cells_o (read_row_cells_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly no gap, some short, a few long; occasional calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pick_pattern();
    logic [63:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: return a;
      1: return a & b & c;
      2: return a & b;
      3: return a | b;
      4: return 64'd0;
      5: return '1;
      default: return {56'd0, a[7:0]} << b[5:0];
    endcase
  endfunction

  // one transaction on the request channel, then the grid copy follows it
  task automatic send_request(input logic [1:0] req, input logic [5:0] row,
                              input logic [63:0] cells, input logic pinned = 1'b0,
                              input logic [63:0] want = '0);
    int gap;
    int cnt;
    logic [63:0] old_grid [ROWS];
    logic [65:0] up, mid, dn;
    logic [63:0] next_row;
    row_read_t   rd;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i  <= 1'b0;
      req_type_i  <= 2'($urandom);
      row_index_i <= 6'($urandom);
      row_cells_i <= {$urandom, $urandom};
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    row_index_i <= row;
    row_cells_i <= cells;
    do @(posedge clk_i); while (!in_ready_o);

    case (req)
      lage_pkg::REQ_WRITE: begin
        if (int'(row) < ROWS) life_grid[row] = cells & COL_MASK;
      end
      lage_pkg::REQ_STEP: begin
        old_grid = life_grid;
        for (int r = 0; r < ROWS; r++) begin
          // pad with a dead column on each side so edges need no special case
          up  = {1'b0, (r > 0) ? old_grid[r-1] : 64'd0, 1'b0};
          mid = {1'b0, old_grid[r], 1'b0};
          dn  = {1'b0, (r < ROWS - 1) ? old_grid[r+1] : 64'd0, 1'b0};
          next_row = '0;
          for (int c = 0; c < COLS; c++) begin
            cnt = up[c] + up[c+1] + up[c+2] + mid[c] + mid[c+2]
                + dn[c] + dn[c+1] + dn[c+2];
            next_row[c] = (cnt == lage_pkg::BIRTH_COUNT)
                       || (mid[c+1] && cnt == lage_pkg::SURVIVE_COUNT);
          end
          life_grid[r] = next_row & COL_MASK;
        end
      end
      lage_pkg::REQ_READ: begin
        rd.row = row;
        if (pinned) rd.cells = want;
        else rd.cells = (int'(row) < ROWS) ? (life_grid[row] & COL_MASK) : 64'd0;
        pending_reads.push_back(rd);
      end
      default: ;
    endcase
    if (req != REQ_UNUSED) served_reqs++;
  endtask

  // result side: random back-pressure and in-order comparison
  always @(posedge clk_i) begin : read_checker
    row_read_t exp_rd;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected read result: row %0d cells %h", read_row_index_o,
               read_row_cells_o);
        mismatch_count++;
      end else begin
        exp_rd = pending_reads.pop_front();
        if (read_row_index_o !== exp_rd.row) begin
          $error("read_row_index: expected %0d, got %0d", exp_rd.row, read_row_index_o);
          mismatch_count++;
        end
        if (read_row_cells_o !== exp_rd.cells) begin
          $error("read_row_cells: expected %h, got %h", exp_rd.cells, read_row_cells_o);
          mismatch_count++;
        end
      end
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready_i <= 1'b0;
    end else begin
      rx_stall = pick_gap(rx_calm);
      out_ready_i <= (rx_stall == 0);
    end
  end

  initial begin : stimulus
    logic [5:0] base;
    int span;
    int steps;
    int kind;
    foreach (life_grid[r]) life_grid[r] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_tbl[i])
      send_request(directed_tbl[i].req, directed_tbl[i].row, directed_tbl[i].cells,
                   directed_tbl[i].pinned, directed_tbl[i].want);

    served_reqs = 0;
    while (served_reqs < RANDOM_REQS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // seed a band of rows, run it a few generations, read back the band plus a row each side
        base  = 6'($urandom);
        span  = $urandom_range(1, 10);
        steps = $urandom_range(1, 4);
        for (int i = 0; i < span; i++)
          send_request(lage_pkg::REQ_WRITE, base + 6'(i), pick_pattern());
        for (int s = 0; s < steps; s++) begin
          send_request(lage_pkg::REQ_STEP, 6'($urandom), {$urandom, $urandom});
          for (int i = 0; i < span + 2; i++)
            send_request(lage_pkg::REQ_READ, base - 6'd1 + 6'(i), {$urandom, $urandom});
        end
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 8))
          send_request(2'($urandom), 6'($urandom), pick_pattern());
      end else begin
        for (int r = 0; r < ROWS; r++)
          send_request(lage_pkg::REQ_READ, 6'(r), {$urandom, $urandom});
      end
    end
    in_valid_i <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
